FILE: hdl/ptse_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package ptse_pkg;

    localparam int unsigned NUM_PEERS_DEF = 256;
    localparam int unsigned HIST_BINS_DEF = 66;
    localparam int unsigned PEER_W        = 8;
    localparam int unsigned SIZE_W        = 64;
    localparam int unsigned CNT_W         = 64;
    localparam int unsigned SEL_W         = 7;
    localparam int unsigned BIN_W         = 7;
    localparam int unsigned CMD_W         = 3;
    localparam int unsigned MODE_W        = 2;

    localparam logic [CMD_W-1:0] CMD_SEND      = 3'd0;
    localparam logic [CMD_W-1:0] CMD_RECV      = 3'd1;
    localparam logic [CMD_W-1:0] CMD_READ      = 3'd2;
    localparam logic [CMD_W-1:0] CMD_READ_CLR  = 3'd3;
    localparam logic [CMD_W-1:0] CMD_CLEAR_ALL = 3'd4;

    localparam logic [MODE_W-1:0] MODE_OFF    = 2'd0;
    localparam logic [MODE_W-1:0] MODE_FILTER = 2'd1;

    // Operations handed from the front to the back.
    typedef enum logic [2:0] {
        OP_SEND_PLAIN,
        OP_SEND_INT,
        OP_RECV,
        OP_READ,
        OP_READ_CLR,
        OP_READ_CLR_INT,
        OP_READ_NULL,
        OP_CLEAR_ALL
    } op_t;

    typedef struct packed {
        op_t               op;
        logic [PEER_W-1:0] peer;
        logic [SIZE_W-1:0] size;
        logic [BIN_W-1:0]  bin;
        logic              bin_ok;
    } cmd_t;

    // Bin: 0 for zero, else leading-one position plus one.
    function automatic logic [BIN_W-1:0] size_bin(input logic [SIZE_W-1:0] s);
        logic [BIN_W-1:0] r;
        r = '0;
        for (int i = 0; i < SIZE_W; i++) begin
            if (s[i]) r = BIN_W'(i + 1);
        end
        return r;
    endfunction

endpackage
`default_nettype wire

FILE: hdl/ptse_front.sv
`timescale 1ns / 1ps
`default_nettype none
module ptse_front #(
    parameter int unsigned NUM_PEERS = ptse_pkg::NUM_PEERS_DEF,
    parameter int unsigned HIST_BINS = ptse_pkg::HIST_BINS_DEF
) (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic [ptse_pkg::MODE_W-1:0]  mode,
    input  wire logic                         in_valid,
    output logic                              in_ready,
    input  wire logic [ptse_pkg::CMD_W-1:0]   command,
    input  wire logic [ptse_pkg::PEER_W-1:0]  peer,
    input  wire logic [ptse_pkg::SIZE_W-1:0]  msg_len,
    input  wire logic                         tag_negative,
    input  wire logic [ptse_pkg::SEL_W-1:0]   bin_select,
    output logic                              cmd_valid,
    input  wire logic                         cmd_ready,
    output ptse_pkg::cmd_t                    cmd
);
    import ptse_pkg::*;

    localparam int unsigned QD = 2;

    cmd_t q_reg [QD];
    logic [1:0] cnt_reg, cnt_next;
    logic       wp_reg, rp_reg;
    cmd_t       cls;
    logic       keep;
    logic       peer_ok;
    logic [BIN_W-1:0] b;

    assign in_ready  = (cnt_reg != 2'(QD));
    assign cmd_valid = (cnt_reg != 2'd0);
    assign cmd       = q_reg[rp_reg];

    // Classify one item into a back-end operation.
    always_comb begin
        peer_ok    = (32'(peer) < NUM_PEERS);
        b          = size_bin(msg_len);
        if (32'(b) >= HIST_BINS) b = BIN_W'(HIST_BINS - 1);
        cls.peer   = peer;
        cls.size   = msg_len;
        cls.bin    = (command == CMD_SEND) ? b : bin_select;
        cls.bin_ok = (32'(bin_select) < HIST_BINS);
        cls.op     = OP_READ_NULL;
        keep       = 1'b0;
        unique case (command)
            CMD_SEND: begin
                keep   = (mode != MODE_OFF) && peer_ok;
                cls.op = (tag_negative && mode == MODE_FILTER) ? OP_SEND_INT
                                                                : OP_SEND_PLAIN;
            end
            CMD_RECV: begin
                keep   = (mode != MODE_OFF) && peer_ok;
                cls.op = OP_RECV;
            end
            CMD_READ: begin
                keep   = 1'b1;
                cls.op = peer_ok ? OP_READ : OP_READ_NULL;
            end
            CMD_READ_CLR: begin
                keep   = 1'b1;
                cls.op = !peer_ok ? OP_READ_NULL :
                         (mode == MODE_FILTER) ? OP_READ_CLR_INT : OP_READ_CLR;
            end
            CMD_CLEAR_ALL: begin
                keep   = 1'b1;
                cls.op = OP_CLEAR_ALL;
            end
            default: keep = 1'b0;
        endcase
    end

    logic push, pop;
    assign push = in_valid && in_ready && keep;
    assign pop  = cmd_valid && cmd_ready;
    always_comb cnt_next = cnt_reg + 2'(push) - 2'(pop);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
        end else begin
            cnt_reg <= cnt_next;
            if (push) wp_reg <= ~wp_reg;
            if (pop)  rp_reg <= ~rp_reg;
        end
        if (push) q_reg[wp_reg] <= cls;
    end

endmodule
`default_nettype wire

FILE: hdl/ptse_back.sv
`timescale 1ns / 1ps
`default_nettype none
module ptse_back #(
    parameter int unsigned NUM_PEERS = ptse_pkg::NUM_PEERS_DEF,
    parameter int unsigned HIST_BINS = ptse_pkg::HIST_BINS_DEF
) (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        cmd_valid,
    output logic                             cmd_ready,
    input  wire ptse_pkg::cmd_t              cmd,
    output logic                             m_valid,
    input  wire logic                        m_ready,
    output logic [ptse_pkg::CNT_W-1:0]       m_sent_bytes,
    output logic [ptse_pkg::CNT_W-1:0]       m_sent_messages,
    output logic [ptse_pkg::CNT_W-1:0]       m_internal_bytes,
    output logic [ptse_pkg::CNT_W-1:0]       m_internal_messages,
    output logic [ptse_pkg::CNT_W-1:0]       m_received_bytes,
    output logic [ptse_pkg::CNT_W-1:0]       m_received_messages,
    output logic [ptse_pkg::CNT_W-1:0]       m_bin_count,
    output logic                             busy
);
    import ptse_pkg::*;

    localparam int unsigned PA_W  = (NUM_PEERS > 1) ? $clog2(NUM_PEERS) : 1;
    localparam int unsigned HB_W  = $clog2(HIST_BINS);
    localparam int unsigned HD    = NUM_PEERS * HIST_BINS;
    localparam int unsigned HA_W  = $clog2(HD);
    localparam int unsigned SW_W  = HA_W + 1;

    typedef enum logic [2:0] { S_CLEAR, S_IDLE, S_READ, S_WRITE, S_OUT } st_t;

    // Totals per peer: 6 words in one row.
    typedef struct packed {
        logic [CNT_W-1:0] pb, pc, ib, ic, rb, rc;
    } row_t;

    row_t             tot_mem  [NUM_PEERS];
    logic [CNT_W-1:0] hist_mem [HD];

    st_t              st_reg;
    cmd_t             c_reg;
    row_t             row_reg;
    logic [CNT_W-1:0] hist_reg;
    logic [SW_W-1:0]  sw_reg;
    logic             mv_reg;
    row_t             out_row_reg;
    logic [CNT_W-1:0] out_bin_reg;
    logic             out_load;

    logic [PA_W-1:0] pa;
    logic [HA_W-1:0] ha;
    assign pa = c_reg.peer[PA_W-1:0];
    assign ha = HA_W'(32'(pa) * HIST_BINS + 32'(c_reg.bin[HB_W-1:0]));

    assign cmd_ready = (st_reg == S_IDLE);
    assign busy      = (st_reg != S_IDLE);
    assign m_valid   = mv_reg;
    assign out_load  = (st_reg == S_OUT) && (!mv_reg || m_ready);
    assign m_sent_bytes        = out_row_reg.pb;
    assign m_sent_messages     = out_row_reg.pc;
    assign m_internal_bytes    = out_row_reg.ib;
    assign m_internal_messages = out_row_reg.ic;
    assign m_received_bytes    = out_row_reg.rb;
    assign m_received_messages = out_row_reg.rc;
    assign m_bin_count         = out_bin_reg;

    row_t wrow;
    always_comb begin
        wrow = row_reg;
        case (c_reg.op)
            OP_SEND_PLAIN: begin
                wrow.pb = row_reg.pb + c_reg.size;
                wrow.pc = row_reg.pc + 64'd1;
            end
            OP_SEND_INT: begin
                wrow.ib = row_reg.ib + c_reg.size;
                wrow.ic = row_reg.ic + 64'd1;
            end
            OP_RECV: begin
                wrow.rb = row_reg.rb + c_reg.size;
                wrow.rc = row_reg.rc + 64'd1;
            end
            OP_READ_CLR: begin
                wrow.pb = '0; wrow.pc = '0; wrow.rb = '0; wrow.rc = '0;
            end
            OP_READ_CLR_INT: wrow = '0;
            default: wrow = row_reg;
        endcase
    end

    // Memories: one address per cycle, registered reads held past the write.
    always_ff @(posedge aclk) begin
        if (st_reg == S_CLEAR) begin
            hist_mem[sw_reg[HA_W-1:0]] <= '0;
            if (32'(sw_reg) < NUM_PEERS) tot_mem[sw_reg[PA_W-1:0]] <= '0;
        end else if (st_reg == S_WRITE) begin
            tot_mem[pa] <= wrow;
            if (c_reg.op == OP_SEND_PLAIN || c_reg.op == OP_SEND_INT)
                hist_mem[ha] <= hist_reg + 64'd1;
        end
        if (st_reg == S_READ) begin
            row_reg  <= tot_mem[pa];
            hist_reg <= hist_mem[ha];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg <= S_CLEAR;
            sw_reg <= '0;
            mv_reg <= 1'b0;
        end else begin
            mv_reg <= out_load || (mv_reg && !m_ready);
            unique case (st_reg)
                S_CLEAR: begin
                    sw_reg <= sw_reg + SW_W'(1);
                    if (32'(sw_reg) == HD - 1) st_reg <= S_IDLE;
                end
                S_IDLE: begin
                    if (cmd_valid) begin
                        c_reg <= cmd;
                        if (cmd.op == OP_CLEAR_ALL) begin
                            sw_reg <= '0;
                            st_reg <= S_CLEAR;
                        end else if (cmd.op == OP_READ_NULL) begin
                            st_reg <= S_OUT;
                        end else begin
                            st_reg <= S_READ;
                        end
                    end
                end
                S_READ: st_reg <= S_WRITE;
                S_WRITE: begin
                    if (c_reg.op == OP_READ || c_reg.op == OP_READ_CLR ||
                        c_reg.op == OP_READ_CLR_INT) st_reg <= S_OUT;
                    else st_reg <= S_IDLE;
                end
                S_OUT: begin
                    if (out_load) begin
                        if (c_reg.op == OP_READ_NULL) begin
                            out_row_reg <= '0;
                            out_bin_reg <= '0;
                        end else begin
                            out_row_reg <= row_reg;
                            out_bin_reg <= c_reg.bin_ok ? hist_reg : '0;
                        end
                        st_reg <= S_IDLE;
                    end
                end
                default: st_reg <= S_IDLE;
            endcase
        end
    end

endmodule
`default_nettype wire

FILE: hdl/peer_traffic_stats_engine_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// Channel   Ports                         Direction  Handshake
// input     s_command .. s_bin_select     in         s_valid / s_ready
// result    m_sent_bytes .. m_bin_count   out        m_valid / m_ready
// config    psel/penable/pwrite/paddr..   in         APB, pready tied high
//
// Events pass the back end as a read state then a write state, reads add an
// output state; the single-port total and histogram memories set these steps.
// After reset, and after each clear-all, a sweep of all NUM_PEERS*HIST_BINS
// addresses zeroes the memories (16896 at the defaults); items queue meanwhile.
// A two-entry queue holds classified items so the input keeps taking items,
// until it fills, while the back end works or the result waits on m_ready.
module peer_traffic_stats_engine_unit #(
    parameter int unsigned NUM_PEERS = ptse_pkg::NUM_PEERS_DEF,
    parameter int unsigned HIST_BINS = ptse_pkg::HIST_BINS_DEF
) (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic                         psel,
    input  wire logic                         penable,
    input  wire logic                         pwrite,
    input  wire logic                         paddr,
    input  wire logic [31:0]                  pwdata,
    output logic [31:0]                       prdata,
    output logic                              pready,
    input  wire logic                         s_valid,
    output logic                              s_ready,
    input  wire logic [ptse_pkg::CMD_W-1:0]   s_command,
    input  wire logic [ptse_pkg::PEER_W-1:0]  s_peer,
    input  wire logic [ptse_pkg::SIZE_W-1:0]  s_msg_len,
    input  wire logic                         s_tag_negative,
    input  wire logic [ptse_pkg::SEL_W-1:0]   s_bin_select,
    output logic                              m_valid,
    input  wire logic                         m_ready,
    output logic [ptse_pkg::CNT_W-1:0]        m_sent_bytes,
    output logic [ptse_pkg::CNT_W-1:0]        m_sent_messages,
    output logic [ptse_pkg::CNT_W-1:0]        m_internal_bytes,
    output logic [ptse_pkg::CNT_W-1:0]        m_internal_messages,
    output logic [ptse_pkg::CNT_W-1:0]        m_received_bytes,
    output logic [ptse_pkg::CNT_W-1:0]        m_received_messages,
    output logic [ptse_pkg::CNT_W-1:0]        m_bin_count
);
    import ptse_pkg::*;

    logic [MODE_W-1:0] mode_reg;
    logic              cmd_valid, cmd_ready, busy;
    cmd_t              cmd;

    // Only register 0 exists; other addresses drop the write.
    assign pready = 1'b1;
    assign prdata = paddr ? 32'd0 : {30'd0, mode_reg};
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg <= MODE_OFF;
        end else if (psel && penable && pwrite && !paddr) begin
            mode_reg <= pwdata[MODE_W-1:0];
        end
    end

    ptse_front #(.NUM_PEERS(NUM_PEERS), .HIST_BINS(HIST_BINS)) u_front (
        .aclk, .aresetn, .mode(mode_reg),
        .in_valid(s_valid), .in_ready(s_ready),
        .command(s_command), .peer(s_peer), .msg_len(s_msg_len),
        .tag_negative(s_tag_negative), .bin_select(s_bin_select),
        .cmd_valid, .cmd_ready, .cmd
    );

    ptse_back #(.NUM_PEERS(NUM_PEERS), .HIST_BINS(HIST_BINS)) u_back (
        .aclk, .aresetn, .cmd_valid, .cmd_ready, .cmd,
        .m_valid, .m_ready,
        .m_sent_bytes, .m_sent_messages, .m_internal_bytes,
        .m_internal_messages, .m_received_bytes, .m_received_messages,
        .m_bin_count, .busy
    );

    // The back end takes a command only when idle.
    a_take_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd_valid && cmd_ready |-> !busy)
        else $error("command taken while back end busy");

    // A taken command leaves the back end busy next cycle.
    a_busy_after: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd_valid && cmd_ready |=> busy)
        else $error("back end not busy after command");

    // Raise a result only as the back end returns to idle.
    a_rise_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> busy == 1'b0)
        else $error("result raised with back end still busy");

endmodule
`default_nettype wire

FILE: tb/tb_top.sv
`timescale 1ns / 1ps
module tb_top;
    import ptse_pkg::*;

    localparam int NPEER = NUM_PEERS_DEF;
    localparam int NBIN  = HIST_BINS_DEF;
    localparam logic [CMD_W-1:0] CMD_UNUSED_LO = 3'd5;

    typedef struct {
        logic [CMD_W-1:0]  command;
        logic [PEER_W-1:0] peer;
        logic [SIZE_W-1:0] msg_len;
        logic              tag_negative;
        logic [SEL_W-1:0]  bin_select;
    } event_t;

    typedef struct {
        logic [CNT_W-1:0] sent_bytes;
        logic [CNT_W-1:0] sent_messages;
        logic [CNT_W-1:0] internal_bytes;
        logic [CNT_W-1:0] internal_messages;
        logic [CNT_W-1:0] received_bytes;
        logic [CNT_W-1:0] received_messages;
        logic [CNT_W-1:0] bin_count;
    } totals_t;

    // Traffic statistics mirror: holds its own copy of every store and the mode,
    // and queues the totals each read should return.
    class traffic_ledger;
        logic [CNT_W-1:0] plain_b [NPEER];
        logic [CNT_W-1:0] plain_n [NPEER];
        logic [CNT_W-1:0] int_b   [NPEER];
        logic [CNT_W-1:0] int_n   [NPEER];
        logic [CNT_W-1:0] recv_b  [NPEER];
        logic [CNT_W-1:0] recv_n  [NPEER];
        logic [CNT_W-1:0] hist    [NPEER][NBIN];
        logic [MODE_W-1:0] mode;
        totals_t pending_reads[$];
        int errors;

        function new();
            mode   = MODE_OFF;
            errors = 0;
            wipe();
        endfunction

        function void wipe();
            for (int p = 0; p < NPEER; p++) begin
                plain_b[p] = '0; plain_n[p] = '0; int_b[p] = '0;
                int_n[p] = '0; recv_b[p] = '0; recv_n[p] = '0;
                for (int b = 0; b < NBIN; b++) hist[p][b] = '0;
            end
        endfunction

        function int log2_bin(logic [SIZE_W-1:0] s);
            int r;
            r = 0;
            for (int i = 0; i < SIZE_W; i++) if (s[i]) r = i + 1;
            return (r >= NBIN) ? NBIN - 1 : r;
        endfunction

        function void note_item(event_t e);
            totals_t t;
            int p;
            p = e.peer;
            case (e.command)
                CMD_SEND: if (mode != MODE_OFF && p < NPEER) begin
                    hist[p][log2_bin(e.msg_len)] += 1;
                    if (e.tag_negative && mode == MODE_FILTER) begin
                        int_b[p] += e.msg_len;
                        int_n[p] += 1;
                    end else begin
                        plain_b[p] += e.msg_len;
                        plain_n[p] += 1;
                    end
                end
                CMD_RECV: if (mode != MODE_OFF && p < NPEER) begin
                    recv_b[p] += e.msg_len;
                    recv_n[p] += 1;
                end
                CMD_READ, CMD_READ_CLR: begin
                    t = '{default: '0};
                    if (p < NPEER) begin
                        t.sent_bytes = plain_b[p];   t.sent_messages = plain_n[p];
                        t.internal_bytes = int_b[p]; t.internal_messages = int_n[p];
                        t.received_bytes = recv_b[p]; t.received_messages = recv_n[p];
                        if (e.bin_select < NBIN) t.bin_count = hist[p][e.bin_select];
                        if (e.command == CMD_READ_CLR) begin
                            plain_b[p] = '0; plain_n[p] = '0;
                            recv_b[p] = '0;  recv_n[p] = '0;
                            if (mode == MODE_FILTER) begin
                                int_b[p] = '0; int_n[p] = '0;
                            end
                        end
                    end
                    pending_reads.push_back(t);
                end
                CMD_CLEAR_ALL: wipe();
                default: ;
            endcase
        endfunction

        function void field(string name, logic [CNT_W-1:0] exp_v, logic [CNT_W-1:0] act_v);
            if (exp_v !== act_v) begin
                $error("%s: expected %0h, got %0h", name, exp_v, act_v);
                errors++;
            end
        endfunction

        function void check_result(totals_t a);
            totals_t e;
            if (pending_reads.size() == 0) begin
                $error("result with no read outstanding");
                errors++;
                return;
            end
            e = pending_reads.pop_front();
            field("sent_bytes", e.sent_bytes, a.sent_bytes);
            field("sent_messages", e.sent_messages, a.sent_messages);
            field("internal_bytes", e.internal_bytes, a.internal_bytes);
            field("internal_messages", e.internal_messages, a.internal_messages);
            field("received_bytes", e.received_bytes, a.received_bytes);
            field("received_messages", e.received_messages, a.received_messages);
            field("bin_count", e.bin_count, a.bin_count);
        endfunction
    endclass

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0, paddr = 1'b0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic pready;
    logic s_valid = 1'b0;
    logic s_ready;
    logic [CMD_W-1:0]  s_command = '0;
    logic [PEER_W-1:0] s_peer = '0;
    logic [SIZE_W-1:0] s_msg_len = '0;
    logic              s_tag_negative = 1'b0;
    logic [SEL_W-1:0]  s_bin_select = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    logic [CNT_W-1:0] m_sent_bytes, m_sent_messages, m_internal_bytes, m_internal_messages;
    logic [CNT_W-1:0] m_received_bytes, m_received_messages, m_bin_count;

    traffic_ledger ledger = new();
    int idle_pct  = 0;   // sender idle chance, percent
    int stall_pct = 0;   // receiver stall chance, percent

    always #2 aclk = ~aclk;

    peer_traffic_stats_engine_unit dut (
        .aclk(aclk), .aresetn(aresetn),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .s_valid(s_valid), .s_ready(s_ready), .s_command(s_command), .s_peer(s_peer),
        .s_msg_len(s_msg_len), .s_tag_negative(s_tag_negative),
        .s_bin_select(s_bin_select),
        .m_valid(m_valid), .m_ready(m_ready),
        .m_sent_bytes(m_sent_bytes), .m_sent_messages(m_sent_messages),
        .m_internal_bytes(m_internal_bytes), .m_internal_messages(m_internal_messages),
        .m_received_bytes(m_received_bytes), .m_received_messages(m_received_messages),
        .m_bin_count(m_bin_count)
    );

    // Receiver: stall at random, change ready only on the falling edge.
    always @(negedge aclk) m_ready <= ($urandom_range(99) >= stall_pct);

    // Sample results on the rising edge where the handshake completes.
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready)
            ledger.check_result('{m_sent_bytes, m_sent_messages, m_internal_bytes,
                                  m_internal_messages, m_received_bytes,
                                  m_received_messages, m_bin_count});
    end

    // Offer one item; called at a falling edge and returns at one.
    task automatic offer(event_t e);
        while ($urandom_range(99) < idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid        <= 1'b1;
        s_command      <= e.command;
        s_peer         <= e.peer;
        s_msg_len      <= e.msg_len;
        s_tag_negative <= e.tag_negative;
        s_bin_select   <= e.bin_select;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        ledger.note_item(e);
        @(negedge aclk);
    endtask

    task automatic offer_fields(logic [CMD_W-1:0] c, logic [PEER_W-1:0] p,
                                logic [SIZE_W-1:0] s, logic t, logic [SEL_W-1:0] b);
        offer('{c, p, s, t, b});
    endtask

    // Drain: a read flushes everything ahead of it, then wait for its result
    // and then let the block settle so it is idle.
    task automatic drain();
        offer_fields(CMD_READ, 8'd0, '0, 1'b0, '0);
        s_valid <= 1'b0;
        while (ledger.pending_reads.size() != 0) @(negedge aclk);
        repeat (20) @(negedge aclk);
    endtask

    task automatic set_mode(logic [MODE_W-1:0] m);
        drain();
        psel <= 1'b1; pwrite <= 1'b1; paddr <= 1'b0; pwdata <= 32'(m); penable <= 1'b0;
        @(negedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        ledger.mode = m;
        @(negedge aclk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        @(negedge aclk);
    endtask

    function automatic event_t random_item();
        event_t e;
        int r;
        r = $urandom_range(999);
        if (r < 420)      e.command = CMD_SEND;
        else if (r < 640) e.command = CMD_RECV;
        else if (r < 830) e.command = CMD_READ;
        else if (r < 970) e.command = CMD_READ_CLR;
        else if (r < 997) e.command = 3'($urandom_range(7, CMD_UNUSED_LO));
        else              e.command = CMD_CLEAR_ALL;
        // Keep most traffic on a few peers so counters grow and reads see them.
        e.peer = ($urandom_range(9) < 7) ? 8'($urandom_range(3)) : 8'($urandom);
        r = $urandom_range(9);
        if (r < 2)      e.msg_len = '0;
        else if (r < 4) e.msg_len = {$urandom, $urandom};
        else            e.msg_len = {$urandom, $urandom} >> $urandom_range(63);
        e.tag_negative = $urandom_range(1);
        e.bin_select = ($urandom_range(9) < 8) ? 7'($urandom_range(NBIN)) : 7'($urandom);
        return e;
    endfunction

    initial begin
        logic [MODE_W-1:0] modes[8] = '{1, 2, 0, 3, 1, 2, 1, 2};
        int idles[4]  = '{0, 49, 0, 36};
        int stalls[4] = '{0, 0, 49, 36};
        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Directed: extremes of every field, each command, the odd cases.
        set_mode(MODE_FILTER);
        offer_fields(CMD_SEND, 8'd0, '0, 1'b0, '0);
        offer_fields(CMD_SEND, 8'd0, 64'd1, 1'b0, '0);
        offer_fields(CMD_SEND, 8'd0, '1, 1'b1, '1);
        offer_fields(CMD_SEND, 8'd255, 64'h8000_0000_0000_0000, 1'b1, '0);
        offer_fields(CMD_RECV, 8'd0, '1, 1'b1, '0);
        offer_fields(CMD_RECV, 8'd0, 64'd5, 1'b0, '0);
        offer_fields(CMD_READ, 8'd0, '0, 1'b0, 7'd0);
        offer_fields(CMD_READ, 8'd0, '0, 1'b0, 7'd64);
        offer_fields(CMD_READ, 8'd0, '1, 1'b1, 7'd127);
        offer_fields(CMD_READ, 8'd255, '0, 1'b0, 7'd64);
        offer_fields(CMD_READ_CLR, 8'd0, '0, 1'b0, 7'd1);
        offer_fields(CMD_READ, 8'd0, '0, 1'b0, 7'd65);
        offer_fields(3'd5, 8'd0, 64'd9, 1'b0, '0);
        offer_fields(3'd6, 8'd0, 64'd9, 1'b0, '0);
        offer_fields(3'd7, 8'd0, 64'd9, 1'b0, '0);
        offer_fields(CMD_CLEAR_ALL, 8'd0, '0, 1'b0, '0);
        offer_fields(CMD_READ, 8'd255, '0, 1'b0, 7'd64);
        set_mode(MODE_OFF);
        offer_fields(CMD_SEND, 8'd1, 64'd7, 1'b0, '0);
        offer_fields(CMD_RECV, 8'd1, 64'd7, 1'b0, '0);
        offer_fields(CMD_READ_CLR, 8'd1, '0, 1'b0, 7'd3);

        // Random phases, cycling mode and handshake pressure.
        for (int ph = 0; ph < 8; ph++) begin
            set_mode(modes[ph]);
            idle_pct  = idles[ph % 4];
            stall_pct = stalls[ph % 4];
            for (int n = 0; n < 125; n++) offer(random_item());
        end
        s_valid <= 1'b0;

        // Hold until every read has come back, then a short settle.
        while (ledger.pending_reads.size() != 0) @(negedge aclk);
        repeat (50) @(negedge aclk);
        if (ledger.errors == 0 && ledger.pending_reads.size() == 0) begin
            $display("tb_top passed");
        end else begin
            $display("tb_top failed");
        end
        $finish;
    end

    initial begin
        #8ms;
        $display("tb_top failed");
        $finish;
    end

endmodule
